/* rtl/osdcv_pkg.sv */
// ----------------------------------------------------------------------------
// osdcv_pkg: shared types and constants for the OSD character canvas
// Opcodes, controller states and the command/status bundles that pass
// between the canvas controller and its datapath.
// ----------------------------------------------------------------------------
package osdcv_pkg;

    // Request opcodes
    localparam logic [2:0] OP_WRITE  = 3'd0;
    localparam logic [2:0] OP_CLEAR  = 3'd1;
    localparam logic [2:0] OP_COMMIT = 3'd2;
    localparam logic [2:0] OP_NEXT   = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    // Entry format
    localparam int         CODE_W     = 10;
    localparam logic [9:0] SPACE_CODE = 10'h020;

    // Controller states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_CLEAR,
        ST_COPY,
        ST_COPY_TAIL,
        ST_DONE
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic take_cmd;     // capture the input request
        logic mem_init;     // zero both canvases at the sweep address
        logic clr_wr;       // write a space to the work canvas at the sweep address
        logic copy_rd;      // read the work canvas at the sweep address
        logic sweep_step;   // advance the sweep counter
        logic char_wr;      // character write from the captured request
        logic shown_rd;     // read the shown canvas for the captured request
        logic commit_flags; // raise frame-ready, drop pending
        logic next_flag;    // drop frame-ready
        logic load_out;     // load the result register
    } ctrl_t;

    // Datapath to controller status
    typedef struct packed {
        logic [2:0] op;         // captured opcode
        logic       pending;    // character written to the work canvas since last commit
        logic       sweep_last; // sweep counter at the last entry
        logic       out_free;   // result register can take a new result
    } status_t;

endpackage

/* rtl/osdcv_ctrl.sv */
// ----------------------------------------------------------------------------
// osdcv_ctrl: canvas controller
// Sequences one request at a time: reset clearing pass, decode, clear and
// copy sweeps, and hand-off of the result to the output register.
// ----------------------------------------------------------------------------
module osdcv_ctrl
    import osdcv_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t stat,
    output ctrl_t   ctrl
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (stat.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (stat.op)
                    OP_CLEAR:  state_next = ST_CLEAR;
                    OP_COMMIT: state_next = stat.pending ? ST_COPY : ST_DONE;
                    default:   state_next = ST_DONE;
                endcase
            end
            ST_CLEAR:
            begin
                if (stat.sweep_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_COPY:
            begin
                if (stat.sweep_last)
                begin
                    state_next = ST_COPY_TAIL;
                end
            end
            ST_COPY_TAIL:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        ctrl     = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                ctrl.mem_init   = 1'b1;
                ctrl.sweep_step = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                ctrl.take_cmd = in_valid;
            end
            ST_EXEC:
            begin
                ctrl.char_wr   = (stat.op == OP_WRITE);
                ctrl.shown_rd  = (stat.op == OP_READ);
                ctrl.next_flag = (stat.op == OP_NEXT);
            end
            ST_CLEAR:
            begin
                ctrl.clr_wr     = 1'b1;
                ctrl.sweep_step = 1'b1;
            end
            ST_COPY:
            begin
                ctrl.copy_rd    = 1'b1;
                ctrl.sweep_step = 1'b1;
            end
            ST_COPY_TAIL:
            begin
                ctrl.commit_flags = 1'b1;
            end
            ST_DONE:
            begin
                ctrl.load_out = stat.out_free;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

`ifndef SYNTHESIS
    // The copy tail always follows the copy sweep
    a_tail_after_copy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COPY_TAIL) |-> ($past(state_reg) == ST_COPY))
        else $error("copy tail entered without a copy sweep");

    // A finished clearing pass opens the block for requests
    a_init_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INIT && stat.sweep_last) |=> (state_reg == ST_IDLE))
        else $error("clearing pass did not end in idle");

    // Sweeps never run while a result is being handed off
    a_no_sweep_at_load: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_out |-> !ctrl.sweep_step)
        else $error("result loaded during a sweep");
`endif

endmodule

/* rtl/osdcv_datapath.sv */
// ----------------------------------------------------------------------------
// osdcv_datapath: canvas datapath
// Request register, work and shown canvas memories, sweep counter, flags
// and the result register.
// ----------------------------------------------------------------------------
module osdcv_datapath
    import osdcv_pkg::*;
#(
    parameter int ROWS      = 16,
    parameter int COLS      = 32,
    parameter int FONT_SIZE = 512
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctrl_t             ctrl,
    output status_t           stat,
    input  logic [2:0]        opcode,
    input  logic [4:0]        row,
    input  logic [5:0]        column,
    input  logic [5:0]        char_offset,
    input  logic [7:0]        attr,
    input  logic [7:0]        char_code,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CODE_W-1:0] read_data,
    output logic              frame_ready,
    output logic              write_pending
);

    localparam int CELLS = ROWS * COLS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

    // Captured request
    logic [2:0] op_reg;
    logic [4:0] row_reg;
    logic [5:0] col_reg;
    logic [5:0] off_reg;
    logic [1:0] page_reg;
    logic [7:0] char_reg;

    // Canvases
    logic [CODE_W-1:0] work_mem  [CELLS];
    logic [CODE_W-1:0] shown_mem [CELLS];
    logic [CODE_W-1:0] work_rd_reg;
    logic [CODE_W-1:0] shown_rd_reg;

    // Sweep and copy pipeline
    logic [AW-1:0] cnt_reg;
    logic [AW-1:0] cnt_next;
    logic          copy_wr_reg;
    logic [AW-1:0] copy_addr_reg;

    // Flags and result
    logic              pending_reg;
    logic              ready_reg;
    logic              out_valid_reg;
    logic [CODE_W-1:0] read_data_reg;
    logic              frame_ready_reg;
    logic              write_pending_reg;

    // Decode
    logic              row_ok;
    logic              col_ok;
    logic [6:0]        col_sum;
    logic              sum_ok;
    logic              wr_ok;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [CODE_W-1:0] code_full;
    logic [CODE_W-1:0] wr_code;
    logic              sweep_last;
    logic              out_free;
    logic [CODE_W-1:0] result_data;

    // Request register
    always_ff @(posedge clk)
    begin
        if (ctrl.take_cmd)
        begin
            op_reg   <= opcode;
            row_reg  <= row;
            col_reg  <= column;
            off_reg  <= char_offset;
            page_reg <= attr[1:0];
            char_reg <= char_code;
        end
    end

    // Range checks and addresses
    assign row_ok    = ({1'b0, row_reg} < 6'(ROWS));
    assign col_ok    = ({1'b0, col_reg} < 7'(COLS));
    assign col_sum   = {1'b0, col_reg} + {1'b0, off_reg};
    assign sum_ok    = (col_sum < 7'(COLS));
    assign wr_ok     = row_ok && col_ok && sum_ok;
    assign wr_addr   = AW'(32'(row_reg) * 32'(COLS) + 32'(col_sum));
    assign rd_addr   = AW'(32'(row_reg) * 32'(COLS) + 32'(col_reg));

    // Character code: font page over byte, bare byte if past the font
    assign code_full = {page_reg, char_reg};
    assign wr_code   = ({1'b0, code_full} < 11'(FONT_SIZE)) ? code_full
                                                            : {2'b00, char_reg};

    // Sweep counter, wraps after the last entry
    assign sweep_last = (cnt_reg == AW'(CELLS - 1));
    assign cnt_next   = sweep_last ? '0 : cnt_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            copy_wr_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.sweep_step)
            begin
                cnt_reg <= cnt_next;
            end
            copy_wr_reg <= ctrl.copy_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        copy_addr_reg <= cnt_reg;
    end

    // Work canvas: one write port, one read port for the copy
    always_ff @(posedge clk)
    begin
        if (ctrl.mem_init)
        begin
            work_mem[cnt_reg] <= '0;
        end
        else if (ctrl.clr_wr)
        begin
            work_mem[cnt_reg] <= SPACE_CODE;
        end
        else if (ctrl.char_wr && wr_ok)
        begin
            work_mem[wr_addr] <= wr_code;
        end
        if (ctrl.copy_rd)
        begin
            work_rd_reg <= work_mem[cnt_reg];
        end
    end

    // Shown canvas: written by init and copy, read for requests
    always_ff @(posedge clk)
    begin
        if (ctrl.mem_init)
        begin
            shown_mem[cnt_reg] <= '0;
        end
        else if (copy_wr_reg)
        begin
            shown_mem[copy_addr_reg] <= work_rd_reg;
        end
        if (ctrl.shown_rd)
        begin
            shown_rd_reg <= shown_mem[rd_addr];
        end
    end

    // Pending and frame-ready flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            ready_reg   <= 1'b0;
        end
        else
        begin
            if (ctrl.commit_flags)
            begin
                pending_reg <= 1'b0;
                ready_reg   <= 1'b1;
            end
            else
            begin
                if (ctrl.char_wr && wr_ok)
                begin
                    pending_reg <= 1'b1;
                end
                if (ctrl.next_flag)
                begin
                    ready_reg <= 1'b0;
                end
            end
        end
    end

    // Result register
    assign out_free    = !out_valid_reg || out_ready;
    assign result_data = (op_reg == OP_READ && row_ok && col_ok) ? shown_rd_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_out)
        begin
            read_data_reg     <= result_data;
            frame_ready_reg   <= ready_reg;
            write_pending_reg <= pending_reg;
        end
    end

    // Status and ports
    assign stat.op         = op_reg;
    assign stat.pending    = pending_reg;
    assign stat.sweep_last = sweep_last;
    assign stat.out_free   = out_free;

    assign out_valid     = out_valid_reg;
    assign read_data     = read_data_reg;
    assign frame_ready   = frame_ready_reg;
    assign write_pending = write_pending_reg;

`ifndef SYNTHESIS
    // The copy write port never collides with the reset clearing pass
    a_copy_vs_init: assert property (@(posedge clk) disable iff (!rst_n)
        !(copy_wr_reg && ctrl.mem_init))
        else $error("copy write during clearing pass");

    // A result is only loaded into a free result register
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_out |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten");

    // A commit leaves frame-ready set and pending clear
    a_commit_flags: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.commit_flags |=> (ready_reg && !pending_reg))
        else $error("commit flags not updated");
`endif

endmodule

/* rtl/osd_char_canvas_double_buffer.sv */
// ----------------------------------------------------------------------------
// osd_char_canvas_double_buffer: double-buffered OSD character store
// Top level: controller and datapath for a work canvas and a shown canvas.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready with opcode, row, column, char_offset,
//   attr and char_code. Each request produces exactly one result on
//   out_valid/out_ready carrying read_data, frame_ready and write_pending
//   (the flags as they stand after the request).
//   Requests are handled one at a time. Write, next-frame, read, unused
//   opcodes and a commit with nothing pending pass through a decode step
//   and then load the result register. Clear first sweeps spaces over the
//   work canvas, and a commit that copies first sweeps the work canvas into
//   the shown canvas and then updates the flags; both sweeps run at one entry
//   per cycle over the canvas memory port. in_ready is high again from the
//   edge that loads the result, so a new request is taken only after that load.
//   The result sits in an output register; the next request is accepted
//   while it waits, and that request then holds in its final step until the
//   receiver takes the earlier result.
//   After reset the block runs a clearing pass that zeroes both canvases;
//   in_ready stays low until it ends.
// ----------------------------------------------------------------------------
module osd_char_canvas_double_buffer
    import osdcv_pkg::*;
#(
    parameter int ROWS      = 16,
    parameter int COLS      = 32,
    parameter int FONT_SIZE = 512
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        opcode,
    input  logic [4:0]        row,
    input  logic [5:0]        column,
    input  logic [5:0]        char_offset,
    input  logic [7:0]        attr,
    input  logic [7:0]        char_code,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CODE_W-1:0] read_data,
    output logic              frame_ready,
    output logic              write_pending
);

    ctrl_t   ctrl;
    status_t stat;

    // Sequencer
    osdcv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    // Canvases, flags and result register
    osdcv_datapath #(
        .ROWS      (ROWS),
        .COLS      (COLS),
        .FONT_SIZE (FONT_SIZE)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .stat          (stat),
        .opcode        (opcode),
        .row           (row),
        .column        (column),
        .char_offset   (char_offset),
        .attr          (attr),
        .char_code     (char_code),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .read_data     (read_data),
        .frame_ready   (frame_ready),
        .write_pending (write_pending)
    );

endmodule
